/* design/fir_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fir_pkg: shared types and constants of the loaded-tap fir filter
// sizes, request codes and the command/status bundles between control and
// datapath
// ----------------------------------------------------------------------------
package fir_pkg;

  // filter size
  localparam int MAX_TAPS = 128;
  localparam int ADDR_W   = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);

  // field widths
  localparam int TAPS_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 7;
  localparam int COEFF_W  = 16;
  localparam int PROD_W   = SAMPLE_W + COEFF_W;
  localparam int ACC_W    = 40;

  // stream payload widths
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  // tdata bit positions of the input fields
  localparam int SAMPLE_LSB = 0;
  localparam int INDEX_LSB  = SAMPLE_LSB + SAMPLE_W;
  localparam int COEFF_LSB  = INDEX_LSB + INDEX_W;

  localparam logic [TAPS_W-1:0] TAPS_RESET = TAPS_W'(128);

  // request kinds carried on tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEFF  = 1'b1;

  typedef struct packed {
    logic accept_sample;
    logic write_coeff;
    logic mac_step;
    logic load_out;
  } fir_cmd_t;

  typedef struct packed {
    logic primed_now;
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } fir_stat_t;

endpackage
`default_nettype wire

/* design/fir_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fir_ctrl: sequencing state machine
// takes requests, steps the multiply-accumulate over the taps, drains the
// pipeline and hands the result to the output register
// ----------------------------------------------------------------------------
module fir_ctrl
  import fir_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      req_type,
  output logic           in_ready,
  input  wire fir_stat_t stat,
  output fir_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next        = state;
    cmd.accept_sample = 1'b0;
    cmd.write_coeff   = 1'b0;
    cmd.mac_step      = 1'b0;
    cmd.load_out      = 1'b0;
    in_ready          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_type == REQ_COEFF) begin
            cmd.write_coeff = 1'b1;
          end else begin
            cmd.accept_sample = 1'b1;
            state_next        = stat.primed_now ? ST_MAC : ST_EMIT;
          end
        end
      end
      ST_MAC: begin
        cmd.mac_step = 1'b1;
        if (stat.last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* design/fir_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fir_dp: filter datapath
// coefficient and delay-line memories, address generation, pipelined
// multiply-accumulate, tap-count register and output register
// ----------------------------------------------------------------------------
module fir_dp
  import fir_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [TAPS_W-1:0]     cfg_wr_data,
  input  wire logic [SAMPLE_W-1:0]   sample_in,
  input  wire logic [INDEX_W-1:0]    coeff_index,
  input  wire logic [COEFF_W-1:0]    coeff_value,
  input  wire fir_cmd_t              cmd,
  output fir_stat_t                  stat,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [ACC_W-1:0]    out_filtered,
  output logic                       out_primed
);

  logic [SAMPLE_W-1:0] delay_mem [MAX_TAPS];
  logic [COEFF_W-1:0]  coeff_mem [MAX_TAPS];

  logic [TAPS_W-1:0] taps_in_use;
  logic [CNT_W-1:0]  taps_eff;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  fill_next;
  logic [ADDR_W-1:0] write_pointer;
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W-1:0] tap_k;
  logic              primed_q;

  logic                       v1;
  logic                       v2;
  logic signed [COEFF_W-1:0]  coef_q;
  logic signed [SAMPLE_W-1:0] samp_q;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;

  // zero taps acts as one, more than the store holds is clamped
  always_comb begin
    if (taps_in_use == '0) begin
      taps_eff = CNT_W'(1);
    end else if (int'(taps_in_use) > MAX_TAPS) begin
      taps_eff = CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = CNT_W'(taps_in_use);
    end
  end

  assign fill_next = (fill_count == CNT_W'(MAX_TAPS)) ? fill_count : fill_count + CNT_W'(1);

  assign stat.primed_now = (fill_next >= taps_eff);
  assign stat.last_tap   = (CNT_W'(tap_k) + CNT_W'(1) == taps_eff);
  assign stat.pipe_busy  = v1 | v2;
  assign stat.out_free   = !out_valid || out_ready;

  // configuration and sample bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      taps_in_use   <= TAPS_RESET;
      fill_count    <= '0;
      write_pointer <= '0;
    end else begin
      if (cfg_wr_en) begin
        taps_in_use <= cfg_wr_data;
      end
      if (cmd.accept_sample) begin
        fill_count    <= fill_next;
        write_pointer <= (int'(write_pointer) == MAX_TAPS - 1) ? '0
                                                              : write_pointer + ADDR_W'(1);
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.write_coeff && int'(coeff_index) < MAX_TAPS) begin
      coeff_mem[ADDR_W'(coeff_index)] <= coeff_value;
    end
    if (cmd.mac_step) begin
      coef_q <= coeff_mem[tap_k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      delay_mem[write_pointer] <= sample_in;
    end
    if (cmd.mac_step) begin
      samp_q <= delay_mem[rd_ptr];
    end
  end

  // tap walk: coefficients upwards, history backwards from the newest sample
  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      rd_ptr   <= write_pointer;
      tap_k    <= '0;
      primed_q <= stat.primed_now;
    end else if (cmd.mac_step) begin
      rd_ptr <= (rd_ptr == '0) ? ADDR_W'(MAX_TAPS - 1) : rd_ptr - ADDR_W'(1);
      tap_k  <= tap_k + ADDR_W'(1);
    end
  end

  // multiply then accumulate
  always_ff @(posedge clk) begin
    prod <= coef_q * samp_q;
    if (cmd.accept_sample) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_step;
      v2 <= v1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_filtered <= primed_q ? acc : '0;
      out_primed   <= primed_q;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(MAX_TAPS))
    else $error("fill count beyond store depth");

  a_load_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !v1 && !v2)
    else $error("result loaded with products still in flight");

  a_accept_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.accept_sample |-> !v1 && !v2 && !cmd.mac_step)
    else $error("sample accepted while accumulating");

  a_unprimed_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out && !primed_q |=> out_filtered == '0 && !out_primed)
    else $error("unprimed result not zero");
`endif

endmodule
`default_nettype wire

/* design/fir_filter_loaded_taps.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fir_filter_loaded_taps: direct-form fir filter with software-loaded taps
// streaming in, streaming out, one tap-count register
// ----------------------------------------------------------------------------
// Each input transaction is either a coefficient write (tuser high), which
// stores one Q1.15 tap and gives no output, or a Q1.15 sample (tuser low),
// which gives exactly one output transaction: the 40-bit Q10.30 sum of
// coefficient[k] * x[n-k] over k below the tap count, flagged primed on tuser,
// or zero with primed low until that many samples have arrived. Once primed, a
// sample walks the taps at one multiply-accumulate per cycle, set by the single
// read port of each tap memory, then drains two pipeline stages and is handed
// over; an unprimed sample skips the walk. A finished result waits in an output
// register, so the next request can be taken while it is pending. The tap count
// register resets to 128; 0 acts as 1 and values above 128 as 128. It may only
// be written while the filter is idle. Coefficients must be loaded before they
// are used.
// ----------------------------------------------------------------------------
module fir_filter_loaded_taps
  import fir_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // tap count register
  input  wire logic                 cfg_wr_en,
  input  wire logic [TAPS_W-1:0]    cfg_wr_data,     // taps_in_use
  // request stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,    // sample_in, coeff_index, coeff_value
  input  wire logic                 s_axis_tuser,    // req_type
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata,    // filtered
  output logic                      m_axis_tuser     // primed
);

  fir_cmd_t  cmd;
  fir_stat_t stat;

  logic signed [ACC_W-1:0] filtered;

  // controller: decides per transaction and paces the tap walk
  fir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .req_type (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: memories, multiply-accumulate and the output register
  fir_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .sample_in    (s_axis_tdata[SAMPLE_LSB +: SAMPLE_W]),
    .coeff_index  (s_axis_tdata[INDEX_LSB +: INDEX_W]),
    .coeff_value  (s_axis_tdata[COEFF_LSB +: COEFF_W]),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_filtered (filtered),
    .out_primed   (m_axis_tuser)
  );

  // the sum fills tdata exactly
  assign m_axis_tdata = M_TDATA_W'(filtered);

endmodule
`default_nettype wire
